[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AOCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define AOCE_NEVER(lbl, cond, msg) \
  `AOCE_ASSERT(lbl, !(cond), msg)

`endif

[hw/rtl/aoce_pkg.sv]
// shared constants, codes and types of the open and closed search store
package aoce_pkg;

  localparam int GRID_SIDE    = 32;
  localparam int TIME_HORIZON = 64;
  localparam int OPEN_DEPTH   = 256;

  localparam int CELL_W   = 5;
  localparam int TIME_W   = 6;
  localparam int F_W      = 8;
  localparam int H_W      = 7;
  localparam int PT_W     = 7;
  localparam int CNT_W    = 9;
  localparam int OPEN_AW  = 8;
  localparam int KEY_AW   = 2 * CELL_W;
  localparam int CLOSED_W = 17;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 72;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_CHECK = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_EMPTY   = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;
  localparam logic [1:0] STS_HORIZON = 2'd3;

  typedef struct packed {
    logic [PT_W-1:0]   ptime;
    logic [CELL_W-1:0] pcol;
    logic [CELL_W-1:0] prow;
    logic [F_W-1:0]    f;
    logic [TIME_W-1:0] ntime;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr;
    logic take;
    logic push;
    logic pop_empty;
    logic key_rd;
    logic key_fin;
    logic scan_init;
    logic scan;
    logic shift_init;
    logic shift;
    logic shift_fin;
    logic test;
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       size_zero;
    logic       scan_done;
    logic       shift_done;
    logic       pop_again;
  } sts_t;

endpackage

[hw/rtl/aoce_dpath.sv]
// datapath: open list memory, closed bitmap, counters and result register
module aoce_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aoce_pkg::ctl_t                ctl,
  output aoce_pkg::sts_t                sts,
  input  logic [1:0]                    in_cmd,
  input  logic [aoce_pkg::IN_W-1:0]     in_data,
  output logic [aoce_pkg::OUT_W-1:0]    res_data,
  output logic [aoce_pkg::CNT_W-1:0]    open_cnt
);
  import aoce_pkg::*;

  entry_t                   open_mem [OPEN_DEPTH];
  logic [TIME_HORIZON-1:0]  bmap [GRID_SIDE*GRID_SIDE];

  logic [1:0]        cmd_r;
  logic [CELL_W-1:0] row_r, col_r, prow_r, pcol_r;
  logic [TIME_W-1:0] kt_r;
  logic [H_W-1:0]    h_r;
  logic [PT_W-1:0]   pt_r;

  logic [CNT_W-1:0]    size_r;
  logic [CLOSED_W-1:0] closed_total_r;
  logic [KEY_AW-1:0]   clr_cnt_r;

  logic [CNT_W-1:0]   ra_r, sh_r;
  logic               vld_r, pend_r;
  logic [OPEN_AW-1:0] cidx_r, pend_addr_r, best_idx_r;
  entry_t             best_r, rdata_r;
  logic [TIME_HORIZON-1:0] bm_rdata_r;

  logic [1:0] res_sts_r;
  entry_t     res_node_r;
  logic       res_wc_r;

  logic signed [PT_W:0] pt_ext, t_s;
  logic        horizon_err, full, push_ok;
  entry_t      new_e;
  logic        scan_rd, sh_rd, open_rd, open_wr, better;
  logic [OPEN_AW-1:0] open_raddr, open_waddr;
  entry_t      open_wdata;
  logic        bm_rd, bm_wr;
  logic [KEY_AW-1:0] bm_raddr, bm_waddr;
  logic [TIME_HORIZON-1:0] bm_wdata;
  logic        key_bit, best_bit, close_new;

  // push: time from the parent, root marked by all ones
  assign pt_ext      = {pt_r[PT_W-1], pt_r};
  assign t_s         = (pt_r == '1) ? '0 : pt_ext + (PT_W+1)'(1);
  assign horizon_err = (t_s < 0) || (t_s >= (PT_W+1)'(TIME_HORIZON));
  assign full        = (size_r == CNT_W'(OPEN_DEPTH));
  assign push_ok     = !horizon_err && !full;

  always_comb begin
    new_e.row   = row_r;
    new_e.col   = col_r;
    new_e.ntime = t_s[TIME_W-1:0];
    new_e.f     = F_W'(t_s[TIME_W-1:0]) + F_W'(h_r);
    new_e.prow  = prow_r;
    new_e.pcol  = pcol_r;
    new_e.ptime = pt_r;
  end

  // open list port control
  assign scan_rd    = ctl.scan && (ra_r < size_r);
  assign sh_rd      = ctl.shift && (sh_r < size_r);
  assign open_rd    = scan_rd || sh_rd;
  assign open_raddr = ctl.scan ? ra_r[OPEN_AW-1:0] : sh_r[OPEN_AW-1:0];
  assign open_wr    = (ctl.push && push_ok) || (ctl.shift && pend_r);
  assign open_waddr = ctl.push ? size_r[OPEN_AW-1:0] : pend_addr_r;
  assign open_wdata = ctl.push ? new_e : rdata_r;

  always_ff @(posedge clk) begin
    if (open_rd) begin
      rdata_r <= open_mem[open_raddr];
    end
    if (open_wr) begin
      open_mem[open_waddr] <= open_wdata;
    end
  end

  // closed bitmap, one row of time bits per cell
  assign key_bit   = bm_rdata_r[kt_r];
  assign best_bit  = bm_rdata_r[best_r.ntime];
  assign close_new = ctl.key_fin && (cmd_r == CMD_CLOSE) && !key_bit;
  assign bm_rd     = ctl.key_rd || ctl.shift_fin;
  assign bm_raddr  = ctl.key_rd ? {row_r, col_r} : {best_r.row, best_r.col};
  assign bm_wr     = ctl.clr || close_new;
  assign bm_waddr  = ctl.clr ? clr_cnt_r : {row_r, col_r};
  assign bm_wdata  = ctl.clr ? '0 : (bm_rdata_r | (TIME_HORIZON'(1) << kt_r));

  always_ff @(posedge clk) begin
    if (bm_rd) begin
      bm_rdata_r <= bmap[bm_raddr];
    end
    if (bm_wr) begin
      bmap[bm_waddr] <= bm_wdata;
    end
  end

  assign better = (rdata_r.f < best_r.f) ||
                  ((rdata_r.f == best_r.f) && (rdata_r.ntime > best_r.ntime));

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r  <= in_cmd;
      row_r  <= in_data[4:0];
      col_r  <= in_data[9:5];
      kt_r   <= in_data[15:10];
      h_r    <= in_data[22:16];
      prow_r <= in_data[27:23];
      pcol_r <= in_data[32:28];
      pt_r   <= in_data[39:33];
    end
    if (ctl.scan_init) begin
      ra_r <= '0;
    end else if (scan_rd) begin
      ra_r <= ra_r + CNT_W'(1);
    end
    if (ctl.scan) begin
      cidx_r <= ra_r[OPEN_AW-1:0];
    end
    if (ctl.scan && vld_r && ((cidx_r == '0) || better)) begin
      best_r     <= rdata_r;
      best_idx_r <= cidx_r;
    end
    if (ctl.shift_init) begin
      sh_r <= {1'b0, best_idx_r} + CNT_W'(1);
    end else if (sh_rd) begin
      sh_r <= sh_r + CNT_W'(1);
    end
    if (ctl.shift) begin
      pend_addr_r <= sh_r[OPEN_AW-1:0] - OPEN_AW'(1);
    end
    priority if (ctl.push) begin
      res_sts_r  <= horizon_err ? STS_HORIZON : (full ? STS_FULL : STS_OK);
      res_node_r <= '0;
      res_wc_r   <= 1'b0;
    end else if (ctl.pop_empty) begin
      res_sts_r  <= STS_EMPTY;
      res_node_r <= '0;
      res_wc_r   <= 1'b0;
    end else if (ctl.key_fin) begin
      res_sts_r  <= STS_OK;
      res_node_r <= '0;
      res_wc_r   <= (cmd_r == CMD_CHECK) && key_bit;
    end else if (ctl.test && !sts.pop_again) begin
      res_sts_r  <= STS_OK;
      res_node_r <= best_r;
      res_wc_r   <= best_bit;
    end else begin
      res_sts_r  <= res_sts_r;
      res_node_r <= res_node_r;
      res_wc_r   <= res_wc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r         <= '0;
      closed_total_r <= '0;
      clr_cnt_r      <= '0;
      vld_r          <= 1'b0;
      pend_r         <= 1'b0;
    end else begin
      if (ctl.clr) begin
        clr_cnt_r <= clr_cnt_r + KEY_AW'(1);
      end
      if (ctl.push && push_ok) begin
        size_r <= size_r + CNT_W'(1);
      end else if (ctl.shift_fin) begin
        size_r <= size_r - CNT_W'(1);
      end
      if (close_new) begin
        closed_total_r <= closed_total_r + CLOSED_W'(1);
      end
      vld_r  <= ctl.scan_init ? 1'b0 : scan_rd;
      pend_r <= ctl.shift_init ? 1'b0 : sh_rd;
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt_r == '1);
    sts.cmd        = cmd_r;
    sts.size_zero  = (size_r == '0);
    sts.scan_done  = !(ra_r < size_r) && !vld_r;
    sts.shift_done = !(sh_r < size_r) && !pend_r;
    sts.pop_again  = best_bit && (size_r != '0);
  end

  assign open_cnt = size_r;
  assign res_data = {1'b0, (size_r == '0), closed_total_r, size_r, res_wc_r,
                     res_node_r.ptime, res_node_r.pcol, res_node_r.prow,
                     res_node_r.f, res_node_r.ntime, res_node_r.col,
                     res_node_r.row, res_sts_r};

endmodule

[hw/rtl/aoce_ctrl.sv]
// controller state machine that sequences each command
module aoce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  aoce_pkg::sts_t sts,
  output aoce_pkg::ctl_t ctl
);
  import aoce_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_KEY   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_TEST  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    ctl        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      S_CLR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.take  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.cmd)
          CMD_PUSH: begin
            ctl.push  = 1'b1;
            state_nxt = S_OUT;
          end
          CMD_POP: begin
            if (sts.size_zero) begin
              ctl.pop_empty = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              ctl.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          CMD_CLOSE, CMD_CHECK: begin
            ctl.key_rd = 1'b1;
            state_nxt  = S_KEY;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_KEY: begin
        ctl.key_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          ctl.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        if (sts.shift_done) begin
          ctl.shift_fin = 1'b1;
          state_nxt     = S_TEST;
        end
      end
      S_TEST: begin
        ctl.test = 1'b1;
        if (sts.pop_again) begin
          ctl.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/astar_open_closed_engine.sv]
// top level of the open and closed store for a space-time a* search
// Each input transaction carries one command and yields exactly one result
// transaction. Push writes the node at the tail of a 256-entry open list and
// close/check read-modify-write one row of the closed bitmap; a push registers
// its result in the dispatch state, a close or check in the key state after the
// bitmap read, and after the result transaction the block returns to idle, where
// the next transaction is accepted. A pop is one linear pass of the open list
// memory (one read per cycle) to find the lowest f (greater time, then older
// entry wins ties), then a compaction pass that moves the entries after the
// winner down by one, then one bitmap read; the pass repeats for each closed
// node that is skipped. Commands are handled one at a time. After reset the
// closed bitmap (1024 rows of 64 time bits) is cleared one row per cycle, so no
// transaction is accepted until every row is cleared.
`include "assert_macros.svh"

module astar_open_closed_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // command[1:0]
  input  logic [1:0]                     in_tuser,
  // row[4:0] col[9:5] key_time[15:10] heuristic[22:16] parent_row[27:23]
  // parent_col[32:28] parent_time[39:33]
  input  logic [aoce_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[1:0] node_row[6:2] node_col[11:7] node_time[17:12] node_f[25:18]
  // out_parent_row[30:26] out_parent_col[35:31] out_parent_time[42:36]
  // was_closed[43] open_count[52:44] closed_count[69:53] open_empty[70] zero[71]
  output logic [aoce_pkg::OUT_W-1:0]     out_tdata
);
  import aoce_pkg::*;

  ctl_t             ctl;
  sts_t             sts;
  logic [CNT_W-1:0] open_cnt;

  // sequencing of every command
  aoce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  // storage and result register
  aoce_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (sts),
    .in_cmd   (in_tuser),
    .in_data  (in_tdata),
    .res_data (out_tdata),
    .open_cnt (open_cnt)
  );

  // one command in flight: never ready while a result waits
  `AOCE_NEVER(a_no_overlap, in_tready && out_tvalid, "ready while result pending")
  // open list never grows past its depth
  `AOCE_ASSERT(a_size_cap, open_cnt <= CNT_W'(OPEN_DEPTH), "open list overflow")
  // a delivered result frees the block for the next transaction
  `AOCE_ASSERT(a_out_idle, out_tvalid && out_tready |=> in_tready, "not idle after result")
  // an accepted command drops ready until its result is taken
  `AOCE_ASSERT(a_take_busy, in_tvalid && in_tready |=> !in_tready, "ready after accept")

endmodule
